### rtl/mcg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the metronome click generator.
// No dependencies.
package mcg_pkg;

  localparam int SineDepthDefault = 256;
  localparam int BeatBitsDefault  = 20;

  localparam int SampleW = 16;
  localparam int BeatLenW = 20;
  localparam int EnvW     = 16;
  localparam int StepW    = 23;
  localparam int PhaseW   = 24;
  localparam int CountInW = 22;
  localparam int MagW     = 15;
  localparam int CfgDataW = 23;
  localparam int CfgIdxW  = 3;

  // Serial multiplier: multiplicand holds magnitude times amplitude, multiplier is 16 bits.
  localparam int MulAW = 31;
  localparam int MulBW = 16;

  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  localparam logic [15:0]   AmpAccent = 16'd32768;
  localparam logic [15:0]   AmpNormal = 16'd19661;
  localparam logic [EnvW-1:0] EnvFull = 16'hFFFF;

  localparam logic [BeatLenW-1:0] BeatLenReset  = 20'd22050;
  localparam logic [EnvW-1:0]     EnvStepReset  = 16'd149;
  localparam logic [StepW-1:0]    AccStepReset  = 23'd380432;
  localparam logic [StepW-1:0]    NormStepReset = 23'd304345;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_COUNT_IN = 2'd1,
    CMD_CANCEL   = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_METRONOME_ON = 3'd0,
    REG_BEAT_LENGTH  = 3'd1,
    REG_ENV_STEP     = 3'd2,
    REG_ACCENT_STEP  = 3'd3,
    REG_NORMAL_STEP  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  // Beat tracker status, valid before the tick updates it.
  typedef struct packed {
    logic click_start;
    logic first_beat;
    logic cnt_done;
  } beat_stat_t;

endpackage

### rtl/mcg_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine table with quadrant mirroring, built at elaboration.
// Depends on mcg_pkg.
module mcg_sine_rom import mcg_pkg::*; #(
  parameter int SineDepth = SineDepthDefault
) (
  input  logic [$clog2(SineDepth)+1:0] pos_i,
  output logic [MagW-1:0]              mag_o,
  output logic                         neg_o
);

  localparam int LgD = $clog2(SineDepth);

  function automatic logic [MagW-1:0] sine_entry(input logic [63:0] th);
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] v;
    t2 = (th * th) >> 30;
    a  = Q30One - t2 / 64'd72;
    a  = Q30One - ((t2 * a) >> 30) / 64'd42;
    a  = Q30One - ((t2 * a) >> 30) / 64'd20;
    a  = Q30One - ((t2 * a) >> 30) / 64'd6;
    s  = (th * a) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return v[MagW-1:0];
  endfunction

  localparam logic [MagW-1:0] PeakEntry = sine_entry(HalfPiQ30);

  logic [MagW-1:0] tab_w [SineDepth];

  for (genvar g = 0; g < SineDepth; g++) begin : g_tab
    localparam logic [63:0] Theta = (64'(g) * HalfPiQ30) / SineDepth;
    assign tab_w[g] = sine_entry(Theta);
  end

  logic [1:0]     quad_w;
  logic [LgD-1:0] k_w;
  logic [LgD-1:0] mirror_w;

  assign quad_w   = pos_i[LgD+1:LgD];
  assign k_w      = pos_i[LgD-1:0];
  assign mirror_w = ~k_w + LgD'(1);

  always_comb begin
    if (quad_w[0]) begin
      mag_o = (k_w == '0) ? PeakEntry : tab_w[mirror_w];
    end else begin
      mag_o = tab_w[k_w];
    end
  end

  assign neg_o = quad_w[1];

endmodule

### rtl/mcg_serial_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on mcg_pkg.
module mcg_serial_mul import mcg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [MulAW-1:0]       a_i,
  input  logic [MulBW-1:0]       b_i,
  output logic [MulAW+MulBW-1:0] prod_o,
  output logic                   done_o
);

  localparam int CntW = $clog2(MulBW);

  logic [MulAW-1:0]       a_q;
  logic [MulAW+MulBW-1:0] acc_q, acc_d;
  logic [CntW-1:0]        cnt_q;
  logic                   busy_q, done_q;
  logic [MulAW:0]         sum_w;

  assign sum_w = {1'b0, acc_q[MulAW+MulBW-1:MulBW]} + (acc_q[0] ? {1'b0, a_q} : '0);
  assign acc_d = {sum_w, acc_q[MulBW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{MulAW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

### rtl/mcg_beat_ctrl.sv
`timescale 1ns / 1ps
// Beat position, beat number and count-in tracking.
// Depends on mcg_pkg.
module mcg_beat_ctrl import mcg_pkg::*; #(
  parameter int BeatBits = BeatBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  logic                count_in_i,
  input  logic                cancel_i,
  input  logic                metronome_on_i,
  input  logic [BeatLenW-1:0] beat_length_i,
  output beat_stat_t          stat_o
);

  localparam int CmpW = (BeatBits > BeatLenW) ? BeatBits : BeatLenW;

  logic [BeatBits-1:0] pos_q;
  logic [1:0]          index_q;
  logic                counting_q;
  logic [CountInW-1:0] left_q;

  logic [BeatLenW-1:0] eff_len_w;
  logic [BeatBits-1:0] next_w;
  logic                active_w;
  logic                wrap_w;

  assign eff_len_w = (beat_length_i == '0) ? BeatLenW'(1) : beat_length_i;
  assign next_w    = pos_q + BeatBits'(1);
  assign wrap_w    = (next_w == '0) || (CmpW'(next_w) >= CmpW'(eff_len_w));
  assign active_w  = metronome_on_i || counting_q;

  assign stat_o.click_start = active_w && (pos_q == '0);
  assign stat_o.first_beat  = (index_q == 2'd0);
  assign stat_o.cnt_done    = counting_q && (left_q <= CountInW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      index_q    <= '0;
      counting_q <= 1'b0;
      left_q     <= '0;
    end else if (count_in_i) begin
      counting_q <= 1'b1;
      left_q     <= {eff_len_w, 2'b00};
      pos_q      <= '0;
      index_q    <= '0;
    end else if (cancel_i) begin
      counting_q <= 1'b0;
      left_q     <= '0;
    end else if (tick_i) begin
      if (active_w) begin
        if (wrap_w) begin
          pos_q   <= '0;
          index_q <= index_q + 2'd1;
        end else begin
          pos_q <= next_w;
        end
      end
      if (counting_q) begin
        if (left_q != '0) left_q <= left_q - CountInW'(1);
        if (left_q <= CountInW'(1)) counting_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/metronome_click_generator_top.sv
`timescale 1ns / 1ps
// Metronome click generator top level: control, tone state and output register.
// Depends on mcg_pkg, mcg_sine_rom, mcg_serial_mul and mcg_beat_ctrl.
//
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one item per audio tick:
//   a command and a signed sample. Command tick adds the current click to the
//   sample with 16-bit saturation; count-in start and cancel only update the
//   beat state and return a result with every field zero. Each item returns
//   exactly one result on the output channel (out_valid_o/out_ready_i).
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at
//   once and are meant for idle periods.
// Sequencing
//   A sounding tick takes two passes of the serial multiplier (magnitude times
//   amplitude, then times envelope) before its result is ready. Silent ticks
//   and other commands skip the multiplier and go straight to the result
//   stage. Only one item is in work at a time.
// Reset and stalls
//   Reset restores the register defaults and clears beat, count-in and tone
//   state. A finished result waits in the output register; the next item is
//   accepted meanwhile, and its result holds until the register frees.
module metronome_click_generator_top import mcg_pkg::*; #(
  parameter int SineTableDepth = SineDepthDefault,
  parameter int BeatBits       = BeatBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  // input items
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                cmd_i,
  input  logic signed [SampleW-1:0] sample_in_i,
  // result items
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic                      beat_start_o,
  output logic                      accent_o,
  output logic                      count_in_done_o
);

  localparam int LgD  = $clog2(SineTableDepth);
  localparam int PosW = LgD + 2;

  // ---------------- configuration registers ----------------
  logic                metronome_on_q;
  logic [BeatLenW-1:0] beat_length_q;
  logic [EnvW-1:0]     env_step_q;
  logic [StepW-1:0]    acc_step_q;
  logic [StepW-1:0]    norm_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metronome_on_q <= 1'b0;
      beat_length_q  <= BeatLenReset;
      env_step_q     <= EnvStepReset;
      acc_step_q     <= AccStepReset;
      norm_step_q    <= NormStepReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_METRONOME_ON: metronome_on_q <= cfg_wdata_i[0];
        REG_BEAT_LENGTH:  beat_length_q  <= cfg_wdata_i[BeatLenW-1:0];
        REG_ENV_STEP:     env_step_q     <= cfg_wdata_i[EnvW-1:0];
        REG_ACCENT_STEP:  acc_step_q     <= cfg_wdata_i[StepW-1:0];
        REG_NORMAL_STEP:  norm_step_q    <= cfg_wdata_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input decode ----------------
  state_e state_q, state_d;
  logic   in_fire_w, is_tick_w;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire_w  = in_valid_i && in_ready_o;
  assign is_tick_w  = (cmd_e'(cmd_i) == CMD_TICK);

  beat_stat_t beat_stat_w;

  mcg_beat_ctrl #(
    .BeatBits(BeatBits)
  ) u_beat (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_i        (in_fire_w && is_tick_w),
    .count_in_i    (in_fire_w && (cmd_e'(cmd_i) == CMD_COUNT_IN)),
    .cancel_i      (in_fire_w && (cmd_e'(cmd_i) == CMD_CANCEL)),
    .metronome_on_i(metronome_on_q),
    .beat_length_i (beat_length_q),
    .stat_o        (beat_stat_w)
  );

  // ---------------- tone state ----------------
  logic [PhaseW-1:0] phase_q;
  logic [EnvW-1:0]   env_q;
  logic              accent_click_q;

  logic [PhaseW-1:0] phase_eff_w;
  logic [EnvW-1:0]   env_eff_w;
  logic              accent_eff_w;
  logic              sounding_w;

  // A starting click resets phase and envelope before this tick uses them.
  assign phase_eff_w  = beat_stat_w.click_start ? '0 : phase_q;
  assign env_eff_w    = beat_stat_w.click_start ? EnvFull : env_q;
  assign accent_eff_w = beat_stat_w.click_start ? beat_stat_w.first_beat : accent_click_q;
  assign sounding_w   = (env_eff_w != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= '0;
      env_q          <= '0;
      accent_click_q <= 1'b0;
    end else if (in_fire_w && is_tick_w) begin
      accent_click_q <= accent_eff_w;
      phase_q        <= phase_eff_w;
      env_q          <= env_eff_w;
      if (sounding_w) begin
        // advance the tone and decay the envelope, stopping at zero
        phase_q <= phase_eff_w + PhaseW'(accent_eff_w ? acc_step_q : norm_step_q);
        env_q   <= (env_eff_w > env_step_q) ? env_eff_w - env_step_q : '0;
      end
    end
  end

  // ---------------- sine lookup ----------------
  logic [MagW-1:0] mag_w;
  logic            neg_w;

  mcg_sine_rom #(
    .SineDepth(SineTableDepth)
  ) u_rom (
    .pos_i(phase_eff_w[PhaseW-1 -: PosW]),
    .mag_o(mag_w),
    .neg_o(neg_w)
  );

  // ---------------- item registers ----------------
  logic                      tick_q, sound_q, neg_q;
  logic                      start_flag_q, acc_flag_q, done_flag_q;
  logic signed [SampleW-1:0] smp_q;
  logic [EnvW-1:0]           env_mul_q;

  always_ff @(posedge clk_i) begin
    if (in_fire_w) begin
      tick_q       <= is_tick_w;
      sound_q      <= is_tick_w && sounding_w;
      neg_q        <= neg_w;
      smp_q        <= sample_in_i;
      env_mul_q    <= env_eff_w;
      start_flag_q <= is_tick_w && beat_stat_w.click_start;
      acc_flag_q   <= is_tick_w && sounding_w && accent_eff_w;
      done_flag_q  <= is_tick_w && beat_stat_w.cnt_done;
    end
  end

  // ---------------- serial multiplier, two passes ----------------
  logic                   mul_start_w, mul_done_w;
  logic [MulAW-1:0]       mul_a_w;
  logic [MulBW-1:0]       mul_b_w;
  logic [MulAW+MulBW-1:0] prod_w;

  always_comb begin
    mul_start_w = 1'b0;
    mul_a_w     = MulAW'(mag_w);
    mul_b_w     = accent_eff_w ? AmpAccent : AmpNormal;
    if (state_q == S_IDLE) begin
      mul_start_w = in_fire_w && is_tick_w && sounding_w;
    end else if (state_q == S_MUL1) begin
      // second pass: scale the amplitude product by the envelope
      mul_start_w = mul_done_w;
      mul_a_w     = prod_w[MulAW-1:0];
      mul_b_w     = env_mul_q;
    end
  end

  mcg_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_w),
    .a_i    (mul_a_w),
    .b_i    (mul_b_w),
    .prod_o (prod_w),
    .done_o (mul_done_w)
  );

  // ---------------- sequencer ----------------
  logic out_load_w;

  assign out_load_w = (state_q == S_FIN) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire_w) state_d = (is_tick_w && sounding_w) ? S_MUL1 : S_FIN;
      S_MUL1: if (mul_done_w) state_d = S_MUL2;
      S_MUL2: if (mul_done_w) state_d = S_FIN;
      S_FIN:  if (out_load_w) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // ---------------- mix and saturate ----------------
  logic [SampleW-1:0]        click_w;
  logic signed [SampleW+1:0] sum_w;
  logic signed [SampleW-1:0] mixed_w;

  // round half up after dropping 32 fraction bits
  assign click_w = {1'b0, prod_w[46:32]} + SampleW'(prod_w[31]);

  always_comb begin
    if (neg_q) sum_w = (SampleW+2)'(smp_q) - $signed({2'b00, click_w});
    else       sum_w = (SampleW+2)'(smp_q) + $signed({2'b00, click_w});
    if (sum_w > 18'sd32767)       mixed_w = 16'sh7FFF;
    else if (sum_w < -18'sd32768) mixed_w = -16'sh8000;
    else                          mixed_w = sum_w[SampleW-1:0];
  end

  // ---------------- output register ----------------
  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_smp_q;
  logic                      out_start_q, out_acc_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load_w) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load_w) begin
      out_smp_q   <= !tick_q ? '0 : (sound_q ? mixed_w : smp_q);
      out_start_q <= start_flag_q;
      out_acc_q   <= acc_flag_q;
      out_done_q  <= done_flag_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_smp_q;
  assign beat_start_o    = out_start_q;
  assign accent_o        = out_acc_q;
  assign count_in_done_o = out_done_q;

  // ---------------- assertions ----------------
  // The multiplier finishes only while the sequencer waits on it.
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done_w |-> (state_q == S_MUL1 || state_q == S_MUL2))
    else $error("multiplier finished outside a multiply pass");

  // A silent tick or a command goes straight to the result stage.
  a_silent_skips_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_w && !(is_tick_w && sounding_w)) |=> (state_q == S_FIN))
    else $error("item without click did not go to the result stage");

  // A new result appears only when the sequencer hands one over.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result appeared without a finished item");

  // A count-in start, cancel or unused command carries no tick flags.
  a_accent_needs_sound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_w && !is_tick_w) |=> !start_flag_q && !acc_flag_q && !done_flag_q)
    else $error("command item raised a tick flag");

endmodule
